@@ design/esc_pkg.sv @@
// Shared types and constants for the environmental sensor compensation pipeline.
// Used by esc_div, env_sensor_compensation and tb_top; depends on nothing.
`default_nettype none

package esc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIXED    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUM      = 3'd4;

	// pressure divider: 64 quotient bits spread over the stages
	localparam int DIV_BITS   = 64;
	localparam int DIV_STAGES = 32;
	localparam int DIV_STEPS  = DIV_BITS / DIV_STAGES;

	localparam logic signed [31:0] HUM_MAX   = 32'sd419430400;
	localparam logic signed [63:0] PRESS_BIAS = 64'sh0000_8000_0000_0000;

	// per-item fields that ride along with the pressure division
	typedef struct packed {
		logic signed [31:0] temp;
		logic [16:0]        hum;
		logic               zero;
	} side_t;

	// one divider stage: num shifts out dividend bits and takes quotient bits
	typedef struct packed {
		logic [63:0] num;
		logic [31:0] den;
		logic [31:0] rem;
		logic        neg;
		side_t       side;
	} div_t;

endpackage

`default_nettype wire

@@ design/esc_div.sv @@
// Pipelined restoring divider for the pressure quotient, magnitudes only.
// Depends on esc_pkg (div_t, DIV_STAGES, DIV_STEPS).
`default_nettype none

module esc_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire esc_pkg::div_t in_data,
	output logic               out_vld,
	output esc_pkg::div_t      out_data
);

	esc_pkg::div_t                     stage_s [esc_pkg::DIV_STAGES];
	logic [esc_pkg::DIV_STAGES-1:0]    vld_s;

	function automatic esc_pkg::div_t div_step(input esc_pkg::div_t d);
		logic [32:0]   r2;
		esc_pkg::div_t o;
		o  = d;
		r2 = {d.rem, d.num[63]};
		if (r2 >= {1'b0, d.den}) begin
			r2    = r2 - {1'b0, d.den};
			o.num = {d.num[62:0], 1'b1};
		end else begin
			o.num = {d.num[62:0], 1'b0};
		end
		o.rem = r2[31:0];
		return o;
	endfunction

	function automatic esc_pkg::div_t div_stage(input esc_pkg::div_t d);
		esc_pkg::div_t o;
		o = d;
		for (int i = 0; i < esc_pkg::DIV_STEPS; i++) begin
			o = div_step(o);
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[esc_pkg::DIV_STAGES-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s[0] <= div_stage(in_data);
			for (int k = 1; k < esc_pkg::DIV_STAGES; k++) begin
				stage_s[k] <= div_stage(stage_s[k-1]);
			end
		end
	end

	assign out_vld  = vld_s[esc_pkg::DIV_STAGES-1];
	assign out_data = stage_s[esc_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

@@ design/env_sensor_compensation.sv @@
// Temperature, pressure and humidity compensation of raw sensor samples.
// Depends on esc_pkg and esc_div.
`default_nettype none

// One sample triple enters per clock while in_ready is high;
// with out_ready held high the block sustains one item per cycle. Most of the
// pipeline is the 32-stage pressure divider (two quotient bits per stage);
// ten stages of temperature, humidity and pressure setup come before it and
// five stages of pressure correction after it. The whole pipeline advances
// together and holds when the output register is full and not taken.
// Coefficient writes are taken at any time (cfg_ready is always high) but
// must only happen while no sample is in flight.
module env_sensor_compensation (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [19:0]                   adc_temp,
	input  wire logic [19:0]                   adc_press,
	input  wire logic [15:0]                   adc_hum,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [31:0]                 temp_centi,
	output logic [31:0]                        press_q24_8,
	output logic                               press_valid,
	output logic [16:0]                        hum_q22_10
);

	// coefficient registers
	logic [47:0] temp_coeffs_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [47:0] mixed_q;
	logic [39:0] hum_coeffs_q;

	logic [15:0]        t1;
	logic signed [31:0] t2, t3;
	logic signed [63:0] p1z, p2, p3, p4, p5, p6, p7, p8, p9;
	logic signed [31:0] h1, h2, h3, h4, h5, h6;

	logic        en;
	logic [10:1] vld_pre;
	logic [47:43] vld_post;

	// stage registers
	logic signed [31:0] a_t2_s1, bb_s1;
	logic [19:0]        ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7;
	logic [15:0]        ah_s1, ah_s2, ah_s3, ah_s4, ah_s5;
	logic signed [31:0] tv1_s2, btv_s2;
	logic signed [31:0] fine_s3;
	logic signed [31:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [33:0] v1_s4;
	logic signed [31:0] x_s4;
	logic signed [63:0] sq_s5, v1p5_s5, v1p2_s5;
	logic signed [31:0] h5x_s5, xh6_s5, xh3_s5;
	logic signed [63:0] v2a_s6, sqp3_s6, v1p5_s6, v1p2_s6;
	logic signed [31:0] left_s6, inner_s6;
	logic signed [63:0] v2_s7, v1b_s7;
	logic signed [31:0] left_s7, ih2_s7;
	logic signed [63:0] m_s8, n_s8;
	logic signed [31:0] x2_s8;
	logic signed [63:0] d_s9, num_s9;
	logic signed [31:0] x2_s9, yy_s9;
	esc_pkg::div_t      req_s10;
	logic signed [63:0] p_s43, p_s44, p_s45, p_s46;
	esc_pkg::side_t     side_s43, side_s44, side_s45, side_s46;
	logic [63:0]        ll_s44;
	logic [31:0]        cross_s44;
	logic signed [63:0] p8p_s44, p8s_s45, p8s_s46;
	logic [63:0]        qq_s45;
	logic signed [63:0] v1q_s46;
	logic signed [31:0] temp_s47;
	logic [31:0]        press_s47;
	logic               pvld_s47;
	logic [16:0]        hum_s47;

	// combinational helpers
	logic signed [31:0] ta, tb, t5;
	logic signed [63:0] v1w;
	logic signed [31:0] ahs, hl, hr, hy, hm, hx;
	logic [20:0]        pd;
	logic [63:0]        pd_sh;
	logic signed [63:0] dmag;
	logic [16:0]        hum_fin;
	esc_pkg::div_t      req_d;
	logic               dres_vld;
	esc_pkg::div_t      dres;
	logic signed [63:0] q, pq, prs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_lo_q    <= '0;
			press_hi_q    <= '0;
			mixed_q       <= '0;
			hum_coeffs_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				esc_pkg::REG_TEMP:     temp_coeffs_q <= cfg_data[47:0];
				esc_pkg::REG_PRESS_LO: press_lo_q    <= cfg_data;
				esc_pkg::REG_PRESS_HI: press_hi_q    <= cfg_data;
				esc_pkg::REG_MIXED:    mixed_q       <= cfg_data[47:0];
				esc_pkg::REG_HUM:      hum_coeffs_q  <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// unpack coefficients
	assign t1  = temp_coeffs_q[15:0];
	assign t2  = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
	assign t3  = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};
	assign p1z = {48'b0, press_lo_q[15:0]};
	assign p2  = {{48{press_lo_q[31]}}, press_lo_q[31:16]};
	assign p3  = {{48{press_lo_q[47]}}, press_lo_q[47:32]};
	assign p4  = {{48{press_lo_q[63]}}, press_lo_q[63:48]};
	assign p5  = {{48{press_hi_q[15]}}, press_hi_q[15:0]};
	assign p6  = {{48{press_hi_q[31]}}, press_hi_q[31:16]};
	assign p7  = {{48{press_hi_q[47]}}, press_hi_q[47:32]};
	assign p8  = {{48{press_hi_q[63]}}, press_hi_q[63:48]};
	assign p9  = {{48{mixed_q[15]}}, mixed_q[15:0]};
	assign h1  = {24'b0, mixed_q[23:16]};
	assign h2  = {{16{mixed_q[39]}}, mixed_q[39:24]};
	assign h3  = {24'b0, mixed_q[47:40]};
	assign h4  = {{16{hum_coeffs_q[15]}}, hum_coeffs_q[15:0]};
	assign h5  = {{16{hum_coeffs_q[31]}}, hum_coeffs_q[31:16]};
	assign h6  = {{24{hum_coeffs_q[39]}}, hum_coeffs_q[39:32]};

	// advance everything together; hold while the output request is not taken
	assign en       = !vld_post[47] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pre  <= '0;
			vld_post <= '0;
		end else if (en) begin
			vld_pre  <= {vld_pre[9:1], in_valid};
			vld_post <= {vld_post[46:43], dres_vld};
		end
	end

	assign ta    = {15'b0, adc_temp[19:3]} - {15'b0, t1, 1'b0};
	assign tb    = {16'b0, adc_temp[19:4]} - {16'b0, t1};
	assign t5    = fine_s3 * 32'sd5 + 32'sd128;
	assign v1w   = {{30{v1_s4[33]}}, v1_s4};
	assign ahs   = {2'b0, ah_s5, 14'b0};
	assign hl    = (ahs - (h4 <<< 20) - h5x_s5 + 32'sd16384) >>> 15;
	assign pd    = 21'd1048576 - {1'b0, ap_s7};
	assign pd_sh = {12'b0, pd, 31'b0};
	assign hr    = (ih2_s7 + 32'sd8192) >>> 14;
	assign hy    = x2_s8 >>> 15;

	// humidity: final correction and clamp
	assign hm = (yy_s9 >>> 7) * h1;
	assign hx = x2_s9 - (hm >>> 4);
	always_comb begin
		if (hx[31]) begin
			hum_fin = '0;
		end else if (hx > esc_pkg::HUM_MAX) begin
			hum_fin = esc_pkg::HUM_MAX[28:12];
		end else begin
			hum_fin = hx[28:12];
		end
	end

	// divider setup: magnitudes and quotient sign
	assign dmag = d_s9[63] ? -d_s9 : d_s9;
	always_comb begin
		req_d.num       = num_s9[63] ? 64'(-num_s9) : 64'(num_s9);
		req_d.den       = dmag[31:0];
		req_d.rem       = '0;
		req_d.neg       = num_s9[63] ^ d_s9[63];
		req_d.side.temp = temp_s9;
		req_d.side.hum  = hum_fin;
		req_d.side.zero = (d_s9 == 64'sd0);
	end

	assign q   = p_s43 >>> 13;
	assign pq  = p9 * $signed(qq_s45);
	assign prs = ((p_s46 + v1q_s46 + p8s_s46) >>> 8) + (p7 <<< 4);

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature
			a_t2_s1 <= ta * t2;
			bb_s1   <= tb * tb;
			ap_s1   <= adc_press;
			ah_s1   <= adc_hum;

			tv1_s2 <= a_t2_s1 >>> 11;
			btv_s2 <= (bb_s1 >>> 12) * t3;
			ap_s2  <= ap_s1;
			ah_s2  <= ah_s1;

			fine_s3 <= tv1_s2 + (btv_s2 >>> 14);
			ap_s3   <= ap_s2;
			ah_s3   <= ah_s2;

			temp_s4 <= t5 >>> 8;
			v1_s4   <= {{2{fine_s3[31]}}, fine_s3} - 34'sd128000;
			x_s4    <= fine_s3 - 32'sd76800;
			ap_s4   <= ap_s3;
			ah_s4   <= ah_s3;

			// pressure and humidity products
			sq_s5   <= v1w * v1w;
			v1p5_s5 <= v1w * p5;
			v1p2_s5 <= v1w * p2;
			h5x_s5  <= h5 * x_s4;
			xh6_s5  <= x_s4 * h6;
			xh3_s5  <= x_s4 * h3;
			ap_s5   <= ap_s4;
			ah_s5   <= ah_s4;
			temp_s5 <= temp_s4;

			v2a_s6   <= sq_s5 * p6;
			sqp3_s6  <= sq_s5 * p3;
			v1p5_s6  <= v1p5_s5;
			v1p2_s6  <= v1p2_s5;
			left_s6  <= hl;
			inner_s6 <= (xh6_s5 >>> 10) * ((xh3_s5 >>> 11) + 32'sd32768);
			ap_s6    <= ap_s5;
			temp_s6  <= temp_s5;

			v2_s7   <= v2a_s6 + (v1p5_s6 <<< 17) + (p4 <<< 35);
			v1b_s7  <= (sqp3_s6 >>> 8) + (v1p2_s6 <<< 12);
			ih2_s7  <= ((inner_s6 >>> 10) + 32'sd2097152) * h2;
			left_s7 <= left_s6;
			ap_s7   <= ap_s6;
			temp_s7 <= temp_s6;

			m_s8    <= (esc_pkg::PRESS_BIAS + v1b_s7) * p1z;
			n_s8    <= $signed(pd_sh) - v2_s7;
			x2_s8   <= left_s7 * hr;
			temp_s8 <= temp_s7;

			d_s9    <= m_s8 >>> 33;
			num_s9  <= n_s8 * 64'sd3125;
			yy_s9   <= hy * hy;
			x2_s9   <= x2_s8;
			temp_s9 <= temp_s8;

			req_s10 <= req_d;

			// pressure after the quotient
			p_s43    <= dres.neg ? -$signed(dres.num) : $signed(dres.num);
			side_s43 <= dres.side;

			ll_s44    <= 64'(q[31:0]) * 64'(q[31:0]);
			cross_s44 <= q[31:0] * q[63:32];
			p8p_s44   <= p8 * p_s43;
			p_s44     <= p_s43;
			side_s44  <= side_s43;

			qq_s45   <= ll_s44 + {cross_s44[30:0], 33'b0};
			p8s_s45  <= p8p_s44 >>> 19;
			p_s45    <= p_s44;
			side_s45 <= side_s44;

			v1q_s46  <= pq >>> 25;
			p8s_s46  <= p8s_s45;
			p_s46    <= p_s45;
			side_s46 <= side_s45;

			temp_s47  <= side_s46.temp;
			hum_s47   <= side_s46.hum;
			pvld_s47  <= !side_s46.zero;
			press_s47 <= side_s46.zero ? 32'd0 : prs[31:0];
		end
	end

	esc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_pre[10]),
		.in_data  (req_s10),
		.out_vld  (dres_vld),
		.out_data (dres)
	);

	assign out_valid   = vld_post[47];
	assign temp_centi  = temp_s47;
	assign press_q24_8 = press_s47;
	assign press_valid = pvld_s47;
	assign hum_q22_10  = hum_s47;

	a_zero_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !press_valid |-> press_q24_8 == 32'd0)
		else $error("pressure not forced to zero on zero divisor");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hum_q22_10 <= 17'd102400)
		else $error("humidity beyond clamp");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_pre) && $stable(vld_post))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for env_sensor_compensation: directed table, then random samples.
// Depends on esc_pkg and the env_sensor_compensation RTL.
`default_nettype none

module tb_top;

	localparam int N_RANDOM    = 1950;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_WAIT  = 60;
	// an index past the register list
	localparam logic [esc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [31:0] temp;
		logic [31:0] press;
		logic        pvalid;
		logic [16:0] hum;
	} reading_t;

	typedef struct {
		logic [19:0] at;
		logic [19:0] ap;
		logic [15:0] ah;
		bit          typed;
		reading_t    want;
	} sample_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [esc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [19:0] adc_temp = '0;
	logic [19:0] adc_press = '0;
	logic [15:0] adc_hum = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] temp_centi;
	logic [31:0] press_q24_8;
	logic press_valid;
	logic [16:0] hum_q22_10;

	env_sensor_compensation dut (.*);

	always #6 clk = ~clk;

	logic [47:0] c_temp;
	logic [63:0] c_plo, c_phi;
	logic [47:0] c_mix;
	logic [39:0] c_hum;

	reading_t pending[$];
	bit failed = 1'b0;
	bit quiet = 1'b0;
	int cycles = 0;

	function automatic logic [31:0] sra32(logic [31:0] v, int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [63:0] sra64(logic [63:0] v, int s);
		return $signed(v) >>> s;
	endfunction

	function automatic reading_t compensate(logic [19:0] at, logic [19:0] ap, logic [15:0] ah);
		logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] a, b, tv1, tv2, fine, x, left, inner, right, y;
		logic [63:0] v1, v2, p, q, na, nb, ma, mb;
		reading_t r;
		t1 = {16'd0, c_temp[15:0]};
		t2 = {{16{c_temp[31]}}, c_temp[31:16]};
		t3 = {{16{c_temp[47]}}, c_temp[47:32]};
		p1 = {48'd0, c_plo[15:0]};
		p2 = {{48{c_plo[31]}}, c_plo[31:16]};
		p3 = {{48{c_plo[47]}}, c_plo[47:32]};
		p4 = {{48{c_plo[63]}}, c_plo[63:48]};
		p5 = {{48{c_phi[15]}}, c_phi[15:0]};
		p6 = {{48{c_phi[31]}}, c_phi[31:16]};
		p7 = {{48{c_phi[47]}}, c_phi[47:32]};
		p8 = {{48{c_phi[63]}}, c_phi[63:48]};
		p9 = {{48{c_mix[15]}}, c_mix[15:0]};
		h1 = {24'd0, c_mix[23:16]};
		h2 = {{16{c_mix[39]}}, c_mix[39:24]};
		h3 = {24'd0, c_mix[47:40]};
		h4 = {{16{c_hum[15]}}, c_hum[15:0]};
		h5 = {{16{c_hum[31]}}, c_hum[31:16]};
		h6 = {{24{c_hum[39]}}, c_hum[39:32]};

		a = {12'd0, at} >> 3;
		a = a - (t1 << 1);
		tv1 = sra32(a * t2, 11);
		b = ({12'd0, at} >> 4) - t1;
		tv2 = sra32(sra32(b * b, 12) * t3, 14);
		fine = tv1 + tv2;
		r.temp = sra32(fine * 32'd5 + 32'd128, 8);

		r.press = '0;
		r.pvalid = 1'b0;
		v1 = {{32{fine[31]}}, fine} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
		v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
		if (v1 != 0) begin
			p = 64'd1048576 - {44'd0, ap};
			na = ((p << 31) - v2) * 64'd3125;
			nb = v1;
			// truncating signed divide on magnitudes
			ma = na[63] ? -na : na;
			mb = nb[63] ? -nb : nb;
			p = ma / mb;
			if (na[63] != nb[63])
				p = -p;
			q = sra64(p, 13);
			v1 = sra64(p9 * q * q, 25);
			v2 = sra64(p8 * p, 19);
			p = sra64(p + v1 + v2, 8) + (p7 << 4);
			r.press = p[31:0];
			r.pvalid = 1'b1;
		end

		x = fine - 32'd76800;
		left = sra32(({16'd0, ah} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
		inner = sra32(x * h6, 10) * (sra32(x * h3, 11) + 32'd32768);
		inner = sra32(inner, 10) + 32'd2097152;
		right = sra32(inner * h2 + 32'd8192, 14);
		x = left * right;
		y = sra32(x, 15);
		x = x - sra32(sra32(y * y, 7) * h1, 4);
		if (x[31])
			x = 0;
		else if (x > 32'd419430400)
			x = 32'd419430400;
		r.hum = x[28:12];
		return r;
	endfunction

	// output side: random stalls, compare each result against the oldest expectation
	always @(posedge clk) begin
		reading_t w;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result temp=%0d press=%h", $time, temp_centi,
					press_q24_8);
				failed = 1'b1;
			end else begin
				w = pending.pop_front();
				if (temp_centi !== w.temp) begin
					$display("%0t: temp exp %h got %h", $time, w.temp, temp_centi);
					failed = 1'b1;
				end
				if (press_q24_8 !== w.press) begin
					$display("%0t: press exp %h got %h", $time, w.press, press_q24_8);
					failed = 1'b1;
				end
				if (press_valid !== w.pvalid) begin
					$display("%0t: press_valid exp %b got %b", $time, w.pvalid, press_valid);
					failed = 1'b1;
				end
				if (hum_q22_10 !== w.hum) begin
					$display("%0t: hum exp %h got %h", $time, w.hum, hum_q22_10);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin : out_side
		int n;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			n = $urandom_range(1, 30);
			repeat (n) @(posedge clk);
		end
	end

	initial begin : watchdog
		wait (cycles >= CYCLE_LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

	// hold the request until taken; the caller drops cfg_valid after the last write
	task automatic write_reg(logic [esc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			esc_pkg::REG_TEMP:     c_temp = val[47:0];
			esc_pkg::REG_PRESS_LO: c_plo = val;
			esc_pkg::REG_PRESS_HI: c_phi = val;
			esc_pkg::REG_MIXED:    c_mix = val[47:0];
			esc_pkg::REG_HUM:      c_hum = val[39:0];
			default: ;
		endcase
	endtask

	task automatic load_coeffs(logic [47:0] t, logic [63:0] lo, logic [63:0] hi,
			logic [47:0] m, logic [39:0] h);
		write_reg(esc_pkg::REG_TEMP, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | t);
		write_reg(esc_pkg::REG_PRESS_LO, lo);
		write_reg(esc_pkg::REG_PRESS_HI, hi);
		write_reg(esc_pkg::REG_MIXED, {16'd0, m});
		write_reg(esc_pkg::REG_HUM, {24'd0, h});
		// index beyond the list is dropped
		write_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop the input request, wait for every expectation, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic send(logic [19:0] at, logic [19:0] ap, logic [15:0] ah, bit typed,
			reading_t want, bit gaps);
		int n;
		reading_t r;
		if (gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			n = $urandom_range(1, 18);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		adc_temp <= at;
		adc_press <= ap;
		adc_hum <= ah;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = compensate(at, ap, ah);
		pending.push_back(typed ? want : r);
	endtask

	initial begin : in_side
		sample_row_t rows[$];
		sample_row_t row;
		reading_t zero_rd;
		int k;
		logic [31:0] hi, lo;
		c_temp = '0; c_plo = '0; c_phi = '0; c_mix = '0; c_hum = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all coefficients zero after reset: divisor zero, everything reads zero
		zero_rd = '{temp: 32'd0, press: 32'd0, pvalid: 1'b0, hum: 17'd0};
		rows.push_back('{20'd0, 20'd0, 16'd0, 1'b1, zero_rd});
		rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, zero_rd});
		rows.push_back('{20'h80000, 20'h12345, 16'h8000, 1'b1, zero_rd});
		foreach (rows[i])
			send(rows[i].at, rows[i].ap, rows[i].ah, rows[i].typed, rows[i].want, 1'b1);
		settle();

		// typical calibration
		load_coeffs({16'd50, 16'd26435, 16'd27504},
			{16'd2855, 16'hFFF9, 16'd3024, 16'd36477},
			{16'hD007, 16'hFFF9, 16'd140, 16'hFF82},
			{8'd0, 16'd361, 8'd75, 16'd6000},
			{8'd30, 16'd50, 16'd331});
		rows.delete();
		rows.push_back('{20'd519888, 20'd415148, 16'd27000, 1'b0, zero_rd});
		rows.push_back('{20'd0, 20'd0, 16'd0, 1'b0, zero_rd});
		rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, zero_rd});
		rows.push_back('{20'hFFFFF, 20'd0, 16'd0, 1'b0, zero_rd});
		rows.push_back('{20'd0, 20'hFFFFF, 16'hFFFF, 1'b0, zero_rd});
		rows.push_back('{20'd450000, 20'd300000, 16'd60000, 1'b0, zero_rd});
		foreach (rows[i])
			send(rows[i].at, rows[i].ap, rows[i].ah, rows[i].typed, rows[i].want, 1'b1);
		settle();

		// extreme coefficients: overflow wrap and humidity clamp at both ends
		load_coeffs(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
		for (k = 0; k < 4; k++)
			send(k[0] ? 20'hFFFFF : 20'd0, k[1] ? 20'hFFFFF : 20'd0, k[0] ? 16'hFFFF : 16'd0,
				1'b0, zero_rd, 1'b1);
		settle();
		load_coeffs(48'h8000_8000_8000, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
			48'h80_8000_8000, 40'h80_8000_8000);
		for (k = 0; k < 4; k++)
			send(k[1] ? 20'hFFFFF : 20'h7FFFF, k[0] ? 20'hFFFFF : 20'd1, k[1] ? 16'hFFFF : 16'd1,
				1'b0, zero_rd, 1'b1);
		settle();

		// random phases: alternately near-typical and fully random coefficients
		for (int ph = 0; ph < 6; ph++) begin
			if (ph % 2 == 0)
				load_coeffs({16'($urandom_range(0, 400)), 16'($urandom_range(20000, 32000)),
						16'($urandom_range(20000, 40000))},
					{16'(32768 - $urandom_range(0, 40000)), 16'($urandom_range(0, 8000)),
						16'(-$urandom_range(0, 20)), 16'($urandom_range(30000, 40000))},
					{16'(-$urandom_range(0, 13000)), 16'(-$urandom_range(0, 20)),
						16'($urandom_range(0, 300)), 16'(-$urandom_range(0, 200))},
					{8'($urandom), 16'($urandom_range(300, 400)), 8'($urandom),
						16'($urandom_range(5000, 7000))},
					{8'($urandom_range(0, 40)), 16'($urandom_range(0, 100)),
						16'($urandom_range(200, 400))});
			else
				load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			if (ph == 5)
				quiet = 1'b1;
			for (k = 0; k < N_RANDOM / 6; k++) begin
				hi = $urandom;
				lo = $urandom;
				send(hi[19:0], lo[19:0], lo[31:16], 1'b0, zero_rd, ph != 5);
			end
			settle();
		end

		if (!failed) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule

`default_nettype wire

@@ env_sensor_compensation.f @@
design/esc_pkg.sv
design/esc_div.sv
design/env_sensor_compensation.sv
sim/tb_top.sv
